// ----- rtl/coalescing_pointer_command_queue_assert.svh -----
// assertion macros for the queue rtl
`ifndef COALESCING_POINTER_COMMAND_QUEUE_ASSERT_SVH
`define COALESCING_POINTER_COMMAND_QUEUE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CPCQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CPCQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cpcq_pkg.sv -----
// types and constants of the coalescing pointer command queue
package cpcq_pkg;

    localparam int QUEUE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int FILL_W      = 11;
    localparam int CMD_W       = 3;
    localparam int KIND_W      = 2;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 88;

    typedef enum logic [CMD_W-1:0] {
        CMD_MOVE  = 3'd0,
        CMD_DOWN  = 3'd1,
        CMD_UP    = 3'd2,
        CMD_POP   = 3'd3,
        CMD_CLEAR = 3'd4
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        KIND_MOVE = 2'd0,
        KIND_DOWN = 2'd1,
        KIND_UP   = 2'd2
    } t_kind;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // input word, last field in the lowest bits
    typedef struct packed {
        logic signed [DATA_W-1:0] delta_y;
        logic signed [DATA_W-1:0] delta_x;
        logic [CMD_W-1:0]         command;
    } t_in_word;

    // result word, last field in the lowest bits
    typedef struct packed {
        logic [FILL_W-1:0]        fill_level;
        logic signed [DATA_W-1:0] pop_dy;
        logic signed [DATA_W-1:0] pop_dx;
        logic [KIND_W-1:0]        pop_kind;
        logic                     pop_valid;
        logic                     dropped_oldest;
        logic                     merged;
        logic                     accepted;
    } t_result;

    // one queue entry as held in the memory
    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] dx;
        logic signed [DATA_W-1:0] dy;
    } t_row;

    // ring index increment with wrap at the queue depth
    function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] idx);
        logic [ADDR_W-1:0] res;
        if (idx == ADDR_W'(QUEUE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = idx + 1'b1;
        end
        return res;
    endfunction

    // ring index decrement with wrap at the queue depth
    function automatic logic [ADDR_W-1:0] prev_slot(input logic [ADDR_W-1:0] idx);
        logic [ADDR_W-1:0] res;
        if (idx == '0) begin
            res = ADDR_W'(QUEUE_DEPTH - 1);
        end else begin
            res = idx - 1'b1;
        end
        return res;
    endfunction

endpackage

// ----- rtl/cpcq_sat_add.sv -----
// signed add that clamps to the range of the data width
module cpcq_sat_add
    import cpcq_pkg::*;
(
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    output logic signed [DATA_W-1:0] o_sum
);

    logic [DATA_W:0] sum_ext;

    // one guard bit shows overflow in either direction
    assign sum_ext = {i_a[DATA_W-1], i_a} + {i_b[DATA_W-1], i_b};

    always_comb begin
        if (sum_ext[DATA_W] != sum_ext[DATA_W-1]) begin
            o_sum = sum_ext[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                    : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            o_sum = sum_ext[DATA_W-1:0];
        end
    end

endmodule

// ----- rtl/coalescing_pointer_command_queue.sv -----
// Coalescing pointer command queue: a ring of 1024 entries in one synchronous
// memory row of kind, dx and dy. Each input word is one command and gives one
// result word. On accept the registered memory read of the newest entry (push)
// or the oldest entry (pop) is issued; in the execute state, once the result
// register is free, the command folds, stores or pops and writes the row back.
// A new word is taken only after the last one has finished. A finished result
// waits in the output register while the next word is read. No memory clearing
// pass runs after reset. The enable register resets to 1; the user must write it
// only while the queue is idle, the block itself does not enforce it.
module coalescing_pointer_command_queue
    import cpcq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // command[2:0], delta_x[34:3], delta_y[66:35], zero pad
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // accepted[0], merged[1], dropped_oldest[2], pop_valid[3], pop_kind[5:4],
    // pop_dx[37:6], pop_dy[69:38], fill_level[80:70], zero pad
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    `include "coalescing_pointer_command_queue_assert.svh"

    localparam int IN_W  = $bits(t_in_word);
    localparam int OUT_W = $bits(t_result);

    t_state            r_state, n_state;
    logic              r_enabled;
    logic [ADDR_W-1:0] r_head, n_head;
    logic [ADDR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;
    t_in_word          r_item;
    logic [ADDR_W-1:0] r_rd_addr;
    t_row              r_rd_row;
    t_result           r_out, n_out;
    logic              r_out_valid, n_out_valid;

    t_row              r_mem [QUEUE_DEPTH];

    t_in_word          in_word;
    logic              in_fire;
    logic [ADDR_W-1:0] rd_addr;
    logic              out_free;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_row              wr_row;
    logic signed [DATA_W-1:0] fold_dx, fold_dy;

    assign in_word       = t_in_word'(s_axis_tdata[IN_W-1:0]);
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - OUT_W){1'b0}}, r_out};

    // pops read the oldest entry, pushes the newest
    assign rd_addr = (in_word.command == CMD_POP) ? r_head : prev_slot(r_tail);

    // saturating fold of the newest queued move
    cpcq_sat_add u_sat_dx (
        .i_a   (r_rd_row.dx),
        .i_b   (r_item.delta_x),
        .o_sum (fold_dx)
    );

    cpcq_sat_add u_sat_dy (
        .i_a   (r_rd_row.dy),
        .i_b   (r_item.delta_y),
        .o_sum (fold_dy)
    );

    // enable register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b1;
        end else if (i_cfg_we) begin
            r_enabled <= i_cfg_wdata;
        end
    end

    // entry memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_row;
        end
        if (in_fire) begin
            r_rd_row <= r_mem[rd_addr];
        end
    end

    // captured command word and its read address
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item    <= in_word;
            r_rd_addr <= rd_addr;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // command execution and next state
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_out       = r_out;
        n_out_valid = r_out_valid && !m_axis_tready;
        wr_en       = 1'b0;
        wr_addr     = r_tail;
        wr_row      = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    case (r_item.command) inside
                        CMD_MOVE, CMD_DOWN, CMD_UP: begin
                            if (r_enabled) begin
                                n_out.accepted = 1'b1;
                                if (r_item.command == CMD_MOVE && r_count != '0
                                        && r_rd_row.kind == KIND_MOVE) begin
                                    // fold into the newest move
                                    n_out.merged = 1'b1;
                                    wr_en        = 1'b1;
                                    wr_addr      = r_rd_addr;
                                    wr_row.kind  = KIND_MOVE;
                                    wr_row.dx    = fold_dx;
                                    wr_row.dy    = fold_dy;
                                end else if (!(r_item.command == CMD_MOVE
                                        && r_item.delta_x == '0
                                        && r_item.delta_y == '0)) begin
                                    // append, dropping the oldest when full
                                    wr_en       = 1'b1;
                                    wr_addr     = r_tail;
                                    wr_row.kind = r_item.command[KIND_W-1:0];
                                    if (r_item.command == CMD_MOVE) begin
                                        wr_row.dx = r_item.delta_x;
                                        wr_row.dy = r_item.delta_y;
                                    end
                                    n_tail = next_slot(r_tail);
                                    if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                                        n_head               = next_slot(r_head);
                                        n_out.dropped_oldest = 1'b1;
                                    end else begin
                                        n_count = r_count + 1'b1;
                                    end
                                end
                            end
                        end
                        CMD_POP: begin
                            if (r_count != '0) begin
                                n_out.pop_valid = 1'b1;
                                n_out.pop_kind  = r_rd_row.kind;
                                if (r_rd_row.kind == KIND_MOVE) begin
                                    n_out.pop_dx = r_rd_row.dx;
                                    n_out.pop_dy = r_rd_row.dy;
                                end
                                n_head  = next_slot(r_head);
                                n_count = r_count - 1'b1;
                            end
                        end
                        CMD_CLEAR: begin
                            n_head  = '0;
                            n_tail  = '0;
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                    n_out.fill_level = FILL_W'(n_count);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // checks
    `CPCQ_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNT_W'(QUEUE_DEPTH),
        "entry count above queue depth")
    `CPCQ_ASSERT_NXT(a_one_in_flight, in_fire, !s_axis_tready,
        "second word taken while one is executing")
    `CPCQ_ASSERT_IMP(a_merge_flags, r_out_valid && r_out.merged,
        r_out.accepted && !r_out.dropped_oldest && !r_out.pop_valid,
        "merged result with inconsistent flags")
    `CPCQ_ASSERT_IMP(a_pop_flags, r_out_valid && r_out.pop_valid,
        !r_out.accepted && r_out.pop_kind != 2'd3,
        "pop result with inconsistent flags")
    `CPCQ_ASSERT_NXT(a_drop_keeps_full, r_state == ST_EXEC && out_free && wr_en
        && r_count == CNT_W'(QUEUE_DEPTH),
        r_count == CNT_W'(QUEUE_DEPTH), "full queue lost an entry on push")

endmodule

// ----- tb/cpcq_result_checker.sv -----
// result checker for the coalescing pointer command queue: predicts and compares every word
`timescale 1ns / 1ps

module cpcq_result_checker
    import cpcq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [S_TDATA_W-1:0] i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [M_TDATA_W-1:0] i_out_data,
    output int                   o_fail_count,
    output int                   o_outstanding
);

    localparam int REPLY_DEPTH = 64;

    // shadow copy of the queue ring and the enable register
    t_kind       ring_kind [QUEUE_DEPTH];
    logic [31:0] ring_dx   [QUEUE_DEPTH];
    logic [31:0] ring_dy   [QUEUE_DEPTH];
    int unsigned ring_head;
    int unsigned ring_tail;
    int unsigned ring_count;
    logic        push_enable;

    // predicted reply words still waiting for the dut
    t_result     reply_buf [REPLY_DEPTH];
    logic [5:0]  reply_wr;
    logic [5:0]  reply_rd;
    int          reply_count;

    t_in_word    cmd_word;
    int          fail_total;
    int          reported;

    // ring index step with wrap at the depth
    function automatic int unsigned ring_step(input int unsigned idx);
        return (idx + 1 == QUEUE_DEPTH) ? 0 : idx + 1;
    endfunction

    // signed add clamped to the 32-bit range
    function automatic logic [31:0] clamp_sum(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return s[31:0];
    endfunction

    // advance the shadow queue by one command and return the reply it gives
    function automatic t_result apply_command(input logic [CMD_W-1:0] cmd,
                                              input logic [31:0] dx, input logic [31:0] dy);
        t_result     r;
        int unsigned newest;
        logic        keep;
        r = '0;
        case (cmd) inside
            CMD_MOVE, CMD_DOWN, CMD_UP: begin
                if (push_enable) begin
                    r.accepted = 1'b1;
                    keep = 1'b1;
                    if (cmd == CMD_MOVE) begin
                        newest = (ring_tail == 0) ? QUEUE_DEPTH - 1 : ring_tail - 1;
                        if (ring_count > 0 && ring_kind[newest] == KIND_MOVE) begin
                            ring_dx[newest] = clamp_sum(ring_dx[newest], dx);
                            ring_dy[newest] = clamp_sum(ring_dy[newest], dy);
                            r.merged = 1'b1;
                            keep = 1'b0;
                        end else if (dx == '0 && dy == '0) begin
                            keep = 1'b0;
                        end
                    end
                    if (keep) begin
                        // full ring: oldest entry makes room
                        if (ring_count == QUEUE_DEPTH) begin
                            ring_head = ring_step(ring_head);
                            ring_count--;
                            r.dropped_oldest = 1'b1;
                        end
                        ring_kind[ring_tail] = t_kind'(cmd[KIND_W-1:0]);
                        ring_dx[ring_tail] = (cmd == CMD_MOVE) ? dx : '0;
                        ring_dy[ring_tail] = (cmd == CMD_MOVE) ? dy : '0;
                        ring_tail = ring_step(ring_tail);
                        ring_count++;
                    end
                end
            end
            CMD_POP: begin
                if (ring_count > 0) begin
                    r.pop_valid = 1'b1;
                    r.pop_kind = ring_kind[ring_head];
                    if (ring_kind[ring_head] == KIND_MOVE) begin
                        r.pop_dx = ring_dx[ring_head];
                        r.pop_dy = ring_dy[ring_head];
                    end
                    ring_head = ring_step(ring_head);
                    ring_count--;
                end
            end
            CMD_CLEAR: begin
                ring_head = 0;
                ring_tail = 0;
                ring_count = 0;
            end
            default: begin
            end
        endcase
        r.fill_level = ring_count[FILL_W-1:0];
        return r;
    endfunction

    // one field compare, first ten mismatches printed
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fail_total++;
            if (reported < 10) begin
                reported++;
                $display("mismatch on %s: expected %h, got %h", name, want, got);
            end
        end
    endtask

    // append a predicted reply word
    task automatic store_reply(input t_result r);
        if (reply_count == REPLY_DEPTH) begin
            fail_total++;
            if (reported < 10) begin
                reported++;
                $display("too many words in flight: expected at most %0d, got %0d",
                         REPLY_DEPTH, reply_count + 1);
            end
            return;
        end
        reply_buf[reply_wr] = r;
        reply_wr = reply_wr + 1'b1;
        reply_count++;
    endtask

    // compare a reply word with the oldest prediction
    task automatic compare_reply(input t_result got);
        t_result want;
        if (reply_count == 0) begin
            fail_total++;
            if (reported < 10) begin
                reported++;
                $display("unexpected reply word %h", got);
            end
            return;
        end
        want = reply_buf[reply_rd];
        reply_rd = reply_rd + 1'b1;
        reply_count--;
        check_field("accepted", 32'(want.accepted), 32'(got.accepted));
        check_field("merged", 32'(want.merged), 32'(got.merged));
        check_field("dropped_oldest", 32'(want.dropped_oldest), 32'(got.dropped_oldest));
        check_field("pop_valid", 32'(want.pop_valid), 32'(got.pop_valid));
        check_field("pop_kind", 32'(want.pop_kind), 32'(got.pop_kind));
        check_field("pop_dx", want.pop_dx, got.pop_dx);
        check_field("pop_dy", want.pop_dy, got.pop_dy);
        check_field("fill_level", 32'(want.fill_level), 32'(got.fill_level));
    endtask

    // watch both channels and the register port at every edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ring_head = 0;
            ring_tail = 0;
            ring_count = 0;
            push_enable = 1'b1;
            reply_wr = '0;
            reply_rd = '0;
            reply_count = 0;
        end else begin
            if (i_cfg_we) begin
                push_enable = i_cfg_wdata;
            end
            if (i_in_valid && i_in_ready) begin
                cmd_word = t_in_word'(i_in_data[$bits(t_in_word)-1:0]);
                store_reply(apply_command(cmd_word.command,
                                          cmd_word.delta_x,
                                          cmd_word.delta_y));
            end
            if (i_out_valid && i_out_ready) begin
                compare_reply(t_result'(i_out_data[$bits(t_result)-1:0]));
            end
        end
        o_fail_count <= fail_total;
        o_outstanding <= reply_count;
    end

endmodule

// ----- tb/coalescing_pointer_command_queue_tb.sv -----
// testbench top for the coalescing pointer command queue: stimulus, stalls and verdict
`timescale 1ns / 1ps

module coalescing_pointer_command_queue_tb;
    import cpcq_pkg::*;

    localparam logic [31:0] MAX_POS   = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN_NEG   = 32'h8000_0000;
    localparam logic [31:0] MINUS_ONE = 32'hFFFF_FFFF;

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic                 i_cfg_wdata   = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    int fail_count;
    int outstanding;
    int src_idle_pct = 8;
    int snk_idle_pct = 46;
    logic last_was_move;

    coalescing_pointer_command_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    cpcq_result_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // hard limit on the run
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // reply side stalls
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // delta with a bias toward the extremes
    function automatic logic [31:0] pick_delta();
        case ($urandom_range(9))
            0: return MAX_POS;
            1: return MIN_NEG;
            2: return '0;
            3: return 32'($urandom_range(15));
            4: return -32'($urandom_range(15));
            default: return $urandom();
        endcase
    endfunction

    // send one command word, idling first at random
    task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [31:0] dx,
                                 input logic [31:0] dy);
        t_in_word w;
        w.command = cmd;
        w.delta_x = dx;
        w.delta_y = dy;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= S_TDATA_W'(w);
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // mixed random command, spare codes included
    task automatic issue_random_command();
        logic [CMD_W-1:0] cmd;
        logic [31:0]      dx;
        logic [31:0]      dy;
        int               r;
        r = $urandom_range(99);
        if (r < 35) cmd = CMD_MOVE;
        else if (r < 48) cmd = CMD_DOWN;
        else if (r < 61) cmd = CMD_UP;
        else if (r < 86) cmd = CMD_POP;
        else if (r < 89) cmd = CMD_CLEAR;
        else cmd = CMD_W'($urandom_range((1 << CMD_W) - 1, CMD_CLEAR + 1));
        dx = pick_delta();
        dy = pick_delta();
        if (cmd == CMD_MOVE && $urandom_range(9) == 0) begin
            dx = '0;
            dy = '0;
        end
        issue_command(cmd, dx, dy);
    endtask

    // push that always lands in a new entry
    task automatic issue_storing_push();
        logic [CMD_W-1:0] cmd;
        logic [31:0]      dx;
        logic [31:0]      dy;
        if (last_was_move) cmd = ($urandom_range(1) != 0) ? CMD_DOWN : CMD_UP;
        else cmd = CMD_W'($urandom_range(CMD_UP));
        dx = pick_delta();
        dy = pick_delta();
        if (cmd == CMD_MOVE && dx == '0 && dy == '0) dy = 32'd1;
        last_was_move = (cmd == CMD_MOVE);
        issue_command(cmd, dx, dy);
    endtask

    // hold the sender until every reply has come back
    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // write the enable register while idle
    task automatic write_enable(input logic value);
        drain_replies();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int src, input int snk);
        src_idle_pct = src;
        snk_idle_pct <= snk;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty pop, zero moves, saturating folds, all kinds
        issue_command(CMD_POP, '0, '0);
        issue_command(CMD_MOVE, '0, '0);
        issue_command(CMD_MOVE, MAX_POS, MIN_NEG);
        issue_command(CMD_MOVE, 32'd1, MINUS_ONE);
        issue_command(CMD_MOVE, MIN_NEG, MAX_POS);
        issue_command(CMD_MOVE, '0, '0);
        issue_command(CMD_DOWN, MAX_POS, MAX_POS);
        issue_command(CMD_MOVE, '0, '0);
        issue_command(CMD_MOVE, MIN_NEG, MIN_NEG);
        issue_command(CMD_MOVE, MIN_NEG, MIN_NEG);
        issue_command(CMD_UP, MINUS_ONE, MINUS_ONE);
        for (int c = CMD_CLEAR + 1; c < (1 << CMD_W); c++) begin
            issue_command(CMD_W'(c), MINUS_ONE, MINUS_ONE);
        end
        repeat (5) issue_command(CMD_POP, MINUS_ONE, MINUS_ONE);
        issue_command(CMD_DOWN, 32'd3, 32'd4);
        issue_command(CMD_CLEAR, '0, '0);
        issue_command(CMD_POP, '0, '0);
        issue_command(CMD_DOWN, '0, '0);
        issue_command(CMD_MOVE, 32'd5, 32'd6);

        // directed: refused pushes, pop and clear still work
        write_enable(1'b0);
        issue_command(CMD_MOVE, 32'd7, 32'd8);
        issue_command(CMD_UP, '0, '0);
        issue_command(CMD_POP, '0, '0);
        issue_command(CMD_CLEAR, '0, '0);
        write_enable(1'b1);

        // mixed random traffic
        repeat (150) issue_random_command();
        write_enable(1'b0);
        repeat (30) issue_random_command();
        write_enable(1'b1);

        // fill past the depth so the oldest entries are dropped
        set_idling(46, 8);
        issue_command(CMD_CLEAR, '0, '0);
        last_was_move = 1'b0;
        repeat (QUEUE_DEPTH + 12) issue_storing_push();
        issue_command(CMD_DOWN, '0, '0);
        issue_command(CMD_MOVE, MAX_POS, MIN_NEG);
        issue_command(CMD_MOVE, MAX_POS, MIN_NEG);
        issue_command(CMD_MOVE, MIN_NEG, MAX_POS);
        repeat (40) issue_command(CMD_POP, pick_delta(), pick_delta());
        drain_replies();

        // back to back, no stalls
        set_idling(0, 0);
        repeat (80) issue_random_command();
        drain_replies();
        repeat (10) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/cpcq_pkg.sv
rtl/cpcq_sat_add.sv
rtl/coalescing_pointer_command_queue.sv
tb/cpcq_result_checker.sv
tb/coalescing_pointer_command_queue_tb.sv
